### hw/rtl/frp_pkg.sv
package frp_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int MAX_NAME_LEN = 256;

    // width of the remaining-entries counter, must hold MAX_ELEMENTS itself
    localparam int ELEM_W = $clog2(MAX_ELEMENTS + 1);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [3:0] KIND_ID       = 4'd0;
    localparam logic [3:0] KIND_NAME     = 4'd1;
    localparam logic [3:0] KIND_FLAGS    = 4'd2;
    localparam logic [3:0] KIND_COUNT    = 4'd3;
    localparam logic [3:0] KIND_MAC      = 4'd4;
    localparam logic [3:0] KIND_MAC_MASK = 4'd5;
    localparam logic [3:0] KIND_IP_VER   = 4'd6;
    localparam logic [3:0] KIND_IP       = 4'd7;
    localparam logic [3:0] KIND_IP_MASK  = 4'd8;
    localparam logic [3:0] KIND_PORT_LO  = 4'd9;
    localparam logic [3:0] KIND_PORT_HI  = 4'd10;
    localparam logic [3:0] KIND_PLEN     = 4'd11;
    localparam logic [3:0] KIND_PATTERN  = 4'd12;
    localparam logic [3:0] KIND_PAT_MASK = 4'd13;

    localparam logic [2:0] LIST_DST_MAC = 3'd1;
    localparam logic [2:0] LIST_DST_IP  = 3'd3;
    localparam logic [2:0] LIST_DST_PORT = 3'd5;
    localparam logic [2:0] LIST_PAYLOAD = 3'd6;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_COUNT     = 2'd1;
    localparam logic [1:0] ERR_NAME_LONG = 2'd2;

    typedef struct packed {
        logic [3:0]  kind;
        logic [2:0]  list;
        logic [9:0]  elem;
        logic [15:0] bidx;
        logic [63:0] value;
        logic        done;
        logic [1:0]  err;
    } token_t;

endpackage

### hw/rtl/frp_front.sv
module frp_front
    import frp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] data_byte,
    input  logic       byte_valid,
    output logic       byte_ready,
    input  logic       q_full,
    output logic       q_push,
    output token_t     q_token
);

    typedef enum logic [3:0] {
        PH_ID,
        PH_NAME,
        PH_FLAGS,
        PH_COUNT,
        PH_MAC,
        PH_IPVER,
        PH_IP,
        PH_PORT,
        PH_PLEN,
        PH_PAT,
        PH_PMASK
    } phase_t;

    localparam logic [15:0] NAME_LIMIT = 16'(MAX_NAME_LEN);

    phase_t            phase_reg, phase_next;
    logic [15:0]       fbc_reg, fbc_next;
    logic [63:0]       acc_reg, acc_next;
    logic [2:0]        list_reg, list_next;
    logic [ELEM_W-1:0] left_reg, left_next;
    logic [9:0]        elem_reg, elem_next;
    logic              v4_reg, v4_next;
    logic [15:0]       plen_reg, plen_next;

    logic              accept;
    logic              emit;
    logic [63:0]       acc_sh;
    logic [15:0]       fbc_inc;
    logic [15:0]       ip_len;
    logic [ELEM_W-1:0] left_dec;
    logic              do_finish;
    logic              do_start;
    logic              do_next_list;
    logic              do_begin;
    token_t            tok;

    assign byte_ready = !q_full;
    assign accept     = byte_valid && !q_full;
    assign acc_sh     = {acc_reg[55:0], data_byte};
    assign fbc_inc    = fbc_reg + 16'd1;
    assign ip_len     = v4_reg ? 16'd4 : 16'd16;
    assign left_dec   = (left_reg != '0) ? left_reg - ELEM_W'(1) : left_reg;

    always_comb
    begin
        phase_next   = phase_reg;
        fbc_next     = fbc_reg;
        acc_next     = acc_sh;
        list_next    = list_reg;
        left_next    = left_reg;
        elem_next    = elem_reg;
        v4_next      = v4_reg;
        plen_next    = plen_reg;
        emit         = 1'b0;
        do_finish    = 1'b0;
        do_start     = 1'b0;
        do_next_list = 1'b0;
        do_begin     = 1'b0;
        tok.kind     = KIND_ID;
        tok.list     = list_reg;
        tok.elem     = elem_reg;
        tok.bidx     = 16'd0;
        tok.value    = {56'd0, data_byte};
        tok.done     = 1'b0;
        tok.err      = ERR_NONE;

        unique case (phase_reg)
            PH_ID:
            begin
                fbc_next = fbc_inc;
                if (fbc_inc >= 16'd4)
                begin
                    emit       = 1'b1;
                    tok.kind   = KIND_ID;
                    tok.value  = {32'd0, acc_sh[31:0]};
                    phase_next = PH_NAME;
                    fbc_next   = 16'd0;
                    acc_next   = 64'd0;
                end
            end
            PH_NAME:
            begin
                acc_next = 64'd0;
                if (data_byte == 8'd0)
                begin
                    // terminator is silent
                    phase_next = PH_FLAGS;
                    fbc_next   = 16'd0;
                end
                else
                begin
                    emit     = 1'b1;
                    tok.kind = KIND_NAME;
                    tok.bidx = fbc_reg;
                    if (fbc_reg >= NAME_LIMIT)
                    begin
                        tok.done = 1'b1;
                        tok.err  = ERR_NAME_LONG;
                        do_begin = 1'b1;
                    end
                    else
                    begin
                        fbc_next = fbc_inc;
                    end
                end
            end
            PH_FLAGS:
            begin
                emit       = 1'b1;
                tok.kind   = KIND_FLAGS;
                list_next  = 3'd0;
                phase_next = PH_COUNT;
                fbc_next   = 16'd0;
                acc_next   = 64'd0;
                elem_next  = 10'd0;
            end
            PH_COUNT:
            begin
                fbc_next = fbc_inc;
                if (fbc_inc >= 16'd8)
                begin
                    emit      = 1'b1;
                    tok.kind  = KIND_COUNT;
                    tok.value = acc_sh;
                    if (acc_sh > 64'(MAX_ELEMENTS))
                    begin
                        tok.done = 1'b1;
                        tok.err  = ERR_COUNT;
                        do_begin = 1'b1;
                    end
                    else
                    begin
                        elem_next = 10'd0;
                        if (acc_sh == 64'd0)
                        begin
                            do_next_list = 1'b1;
                        end
                        else
                        begin
                            left_next = acc_sh[ELEM_W-1:0];
                            do_start  = 1'b1;
                        end
                    end
                end
            end
            PH_MAC:
            begin
                acc_next = 64'd0;
                emit     = 1'b1;
                if (fbc_reg < 16'd6)
                begin
                    tok.kind = KIND_MAC;
                    tok.bidx = fbc_reg;
                end
                else
                begin
                    tok.kind = KIND_MAC_MASK;
                    tok.bidx = fbc_reg - 16'd6;
                end
                fbc_next = fbc_inc;
                if (fbc_inc >= 16'd12)
                begin
                    do_finish = 1'b1;
                end
            end
            PH_IPVER:
            begin
                emit       = 1'b1;
                tok.kind   = KIND_IP_VER;
                v4_next    = (data_byte == 8'd4);
                phase_next = PH_IP;
                fbc_next   = 16'd0;
                acc_next   = 64'd0;
            end
            PH_IP:
            begin
                acc_next = 64'd0;
                emit     = 1'b1;
                if (fbc_reg < ip_len)
                begin
                    tok.kind = KIND_IP;
                    tok.bidx = fbc_reg;
                end
                else
                begin
                    tok.kind = KIND_IP_MASK;
                    tok.bidx = fbc_reg - ip_len;
                end
                fbc_next = fbc_inc;
                if (fbc_inc >= {ip_len[14:0], 1'b0})
                begin
                    do_finish = 1'b1;
                end
            end
            PH_PORT:
            begin
                fbc_next = fbc_inc;
                if (fbc_inc == 16'd2)
                begin
                    emit      = 1'b1;
                    tok.kind  = KIND_PORT_LO;
                    tok.value = {48'd0, acc_sh[15:0]};
                    acc_next  = 64'd0;
                end
                else if (fbc_inc >= 16'd4)
                begin
                    emit      = 1'b1;
                    tok.kind  = KIND_PORT_HI;
                    tok.value = {48'd0, acc_sh[15:0]};
                    do_finish = 1'b1;
                end
            end
            PH_PLEN:
            begin
                fbc_next = fbc_inc;
                if (fbc_inc >= 16'd2)
                begin
                    emit      = 1'b1;
                    tok.kind  = KIND_PLEN;
                    tok.value = {48'd0, acc_sh[15:0]};
                    plen_next = acc_sh[15:0];
                    fbc_next  = 16'd0;
                    acc_next  = 64'd0;
                    if (acc_sh[15:0] == 16'd0)
                    begin
                        do_finish = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_PAT;
                    end
                end
            end
            PH_PAT:
            begin
                acc_next = 64'd0;
                emit     = 1'b1;
                tok.kind = KIND_PATTERN;
                tok.bidx = fbc_reg;
                fbc_next = fbc_inc;
                if (fbc_inc >= plen_reg)
                begin
                    phase_next = PH_PMASK;
                    fbc_next   = 16'd0;
                end
            end
            PH_PMASK:
            begin
                acc_next = 64'd0;
                emit     = 1'b1;
                tok.kind = KIND_PAT_MASK;
                tok.bidx = fbc_reg;
                fbc_next = fbc_inc;
                if (fbc_inc >= plen_reg)
                begin
                    do_finish = 1'b1;
                end
            end
            default:
            begin
                do_begin = 1'b1;
            end
        endcase

        // end of one entry: step the entry counters
        if (do_finish)
        begin
            elem_next = elem_reg + 10'd1;
            left_next = left_dec;
            if (left_dec == '0)
            begin
                do_next_list = 1'b1;
            end
            else
            begin
                do_start = 1'b1;
            end
        end

        if (do_start)
        begin
            fbc_next = 16'd0;
            acc_next = 64'd0;
            if (list_reg <= LIST_DST_MAC)
            begin
                phase_next = PH_MAC;
            end
            else if (list_reg <= LIST_DST_IP)
            begin
                phase_next = PH_IPVER;
            end
            else if (list_reg <= LIST_DST_PORT)
            begin
                phase_next = PH_PORT;
            end
            else
            begin
                phase_next = PH_PLEN;
            end
        end

        if (do_next_list)
        begin
            if (list_reg >= LIST_PAYLOAD)
            begin
                tok.done = 1'b1;
                do_begin = 1'b1;
            end
            else
            begin
                list_next  = list_reg + 3'd1;
                phase_next = PH_COUNT;
                fbc_next   = 16'd0;
                acc_next   = 64'd0;
                elem_next  = 10'd0;
            end
        end

        if (do_begin)
        begin
            phase_next = PH_ID;
            fbc_next   = 16'd0;
            acc_next   = 64'd0;
            list_next  = 3'd0;
            left_next  = '0;
            elem_next  = 10'd0;
            v4_next    = 1'b0;
            plen_next  = 16'd0;
        end
    end

    assign q_push  = accept && emit;
    assign q_token = tok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_ID;
            fbc_reg   <= 16'd0;
            acc_reg   <= 64'd0;
            list_reg  <= 3'd0;
            left_reg  <= '0;
            elem_reg  <= 10'd0;
            v4_reg    <= 1'b0;
            plen_reg  <= 16'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            fbc_reg   <= fbc_next;
            acc_reg   <= acc_next;
            list_reg  <= list_next;
            left_reg  <= left_next;
            elem_reg  <= elem_next;
            v4_reg    <= v4_next;
            plen_reg  <= plen_next;
        end
    end

    a_err_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        q_push && (q_token.err != ERR_NONE) |=> (phase_reg == PH_ID) && (acc_reg == 64'd0))
        else $error("error token did not restart the record");

    a_err_is_done: assert property (@(posedge clk) disable iff (!rst_n)
        q_push && (q_token.err != ERR_NONE) |-> q_token.done)
        else $error("error token without record end");

    a_done_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        q_push && q_token.done |=> (phase_reg == PH_ID) && (list_reg == 3'd0))
        else $error("record end did not return to id");

endmodule

### hw/rtl/frp_queue.sv
module frp_queue
    import frp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  token_t push_token,
    output logic   full,
    input  logic   pop,
    output logic   empty,
    output token_t head_token
);

    token_t            entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full       = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign empty      = (count_reg == '0);
    assign do_push    = push && !full;
    assign do_pop     = pop && !empty;
    assign head_token = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (QPTR_W + 1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (QPTR_W + 1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_token;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("token pushed into a full queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QPTR_W + 1)'(QUEUE_DEPTH))
        else $error("queue count out of range");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) || full || (wr_ptr_reg != rd_ptr_reg))
        else $error("queue pointers disagree with count");

endmodule

### hw/rtl/frp_back.sv
module frp_back
    import frp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    input  token_t      q_head,
    output logic        q_pop,
    output logic        token_valid,
    input  logic        token_ready,
    output logic [3:0]  field_kind,
    output logic [2:0]  list_select,
    output logic [9:0]  element_index,
    output logic [15:0] byte_index,
    output logic [63:0] field_value,
    output logic [1:0]  direction,
    output logic [5:0]  protocol,
    output logic        record_done,
    output logic [1:0]  error_code
);

    logic        valid_reg;
    logic [3:0]  kind_reg;
    logic [2:0]  list_reg;
    logic [9:0]  elem_reg;
    logic [15:0] bidx_reg;
    logic [63:0] value_reg;
    logic [1:0]  dir_reg;
    logic [5:0]  proto_reg;
    logic        done_reg;
    logic [1:0]  err_reg;
    logic        load;
    logic        is_flags;

    // output register is free when empty or being drained this cycle
    assign load     = !q_empty && (!valid_reg || token_ready);
    assign q_pop    = load;
    assign is_flags = (q_head.kind == KIND_FLAGS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (token_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg  <= q_head.kind;
            list_reg  <= (q_head.kind >= KIND_COUNT) ? q_head.list : 3'd0;
            elem_reg  <= (q_head.kind >= KIND_MAC) ? q_head.elem : 10'd0;
            bidx_reg  <= q_head.bidx;
            value_reg <= q_head.value;
            dir_reg   <= is_flags ? q_head.value[7:6] : 2'd0;
            proto_reg <= is_flags ? q_head.value[5:0] : 6'd0;
            done_reg  <= q_head.done;
            err_reg   <= q_head.err;
        end
    end

    assign token_valid   = valid_reg;
    assign field_kind    = kind_reg;
    assign list_select   = list_reg;
    assign element_index = elem_reg;
    assign byte_index    = bidx_reg;
    assign field_value   = value_reg;
    assign direction     = dir_reg;
    assign protocol      = proto_reg;
    assign record_done   = done_reg;
    assign error_code    = err_reg;

    a_pop_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !token_ready |-> !q_pop)
        else $error("output register overwritten while stalled");

    a_flags_only: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && (kind_reg != KIND_FLAGS) |-> (dir_reg == 2'd0) && (proto_reg == 6'd0))
        else $error("flags fields set on a non-flags token");

    a_list_scope: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && (kind_reg < KIND_COUNT) |-> (list_reg == 3'd0) && (elem_reg == 10'd0))
        else $error("list fields set outside a list");

endmodule

### hw/rtl/filter_rule_record_parser_top.sv
// Rule record parser: takes one stream byte per cycle on data_byte while the token queue
// is not full and emits at most one token per byte once a field (an id, a count, a port
// value, a pattern length, or a single name, flags, version, address, mask or pattern byte)
// completes. Each byte is parsed in one combinational step; its token is written into the
// token queue and from there loaded into the output register, from which it transfers. A
// four-entry token queue sits between the parser and the output register, so a
// stalled token output holds off the byte input only after the queue has filled. Records
// follow each other with no framing; an error token (count above the list limit or an
// overlong name) carries record_done and the next byte starts a new record id.
module filter_rule_record_parser_top
    import frp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  data_byte,
    input  logic        byte_valid,
    output logic        byte_ready,
    output logic        token_valid,
    input  logic        token_ready,
    output logic [3:0]  field_kind,
    output logic [2:0]  list_select,
    output logic [9:0]  element_index,
    output logic [15:0] byte_index,
    output logic [63:0] field_value,
    output logic [1:0]  direction,
    output logic [5:0]  protocol,
    output logic        record_done,
    output logic [1:0]  error_code
);

    logic   q_full;
    logic   q_push;
    logic   q_pop;
    logic   q_empty;
    token_t push_token;
    token_t head_token;

    frp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_byte  (data_byte),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_token    (push_token)
    );

    frp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_token (push_token),
        .full       (q_full),
        .pop        (q_pop),
        .empty      (q_empty),
        .head_token (head_token)
    );

    frp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_head        (head_token),
        .q_pop         (q_pop),
        .token_valid   (token_valid),
        .token_ready   (token_ready),
        .field_kind    (field_kind),
        .list_select   (list_select),
        .element_index (element_index),
        .byte_index    (byte_index),
        .field_value   (field_value),
        .direction     (direction),
        .protocol      (protocol),
        .record_done   (record_done),
        .error_code    (error_code)
    );

endmodule

### tb/rule_token_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the rule record parser, predicts the token that each
// accepted byte causes, and compares every token transfer against the oldest prediction.
module rule_token_checker
    import frp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  data_byte,
    input  logic        byte_valid,
    input  logic        byte_ready,
    input  logic        token_valid,
    input  logic        token_ready,
    input  logic [3:0]  field_kind,
    input  logic [2:0]  list_select,
    input  logic [9:0]  element_index,
    input  logic [15:0] byte_index,
    input  logic [63:0] field_value,
    input  logic [1:0]  direction,
    input  logic [5:0]  protocol,
    input  logic        record_done,
    input  logic [1:0]  error_code,
    output int          outstanding,
    output bit          at_rec_start,
    output int          fail_count,
    output int          tokens_checked,
    output int          error_tokens
);

    typedef enum logic [3:0] {
        ST_ID, ST_NAME, ST_FLAGS, ST_COUNT, ST_MAC, ST_IPVER,
        ST_IP, ST_PORT, ST_PLEN, ST_PAT, ST_PMASK
    } parse_state_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [2:0]  lsel;
        logic [9:0]  elem;
        logic [15:0] bidx;
        logic [63:0] value;
        logic [1:0]  dir;
        logic [5:0]  proto;
        logic        done;
        logic [1:0]  err;
    } rule_token_t;

    parse_state_t       cur_phase;
    logic [15:0]        byte_cnt;
    logic [63:0]        shift_acc;
    logic [2:0]         cur_list;
    logic [ELEM_W-1:0]  entries_left;
    logic [9:0]         entry_idx;
    logic               addr_v4;
    logic [15:0]        pat_len;

    rule_token_t        pending_tokens[$];

    function automatic void restart_rule();
        cur_phase    = ST_ID;
        byte_cnt     = '0;
        shift_acc    = '0;
        cur_list     = '0;
        entries_left = '0;
        entry_idx    = '0;
        addr_v4      = 1'b0;
        pat_len      = '0;
    endfunction

    function automatic void open_entry();
        byte_cnt  = '0;
        shift_acc = '0;
        if (cur_list <= LIST_DST_MAC)
            cur_phase = ST_MAC;
        else if (cur_list <= LIST_DST_IP)
            cur_phase = ST_IPVER;
        else if (cur_list <= LIST_DST_PORT)
            cur_phase = ST_PORT;
        else
            cur_phase = ST_PLEN;
    endfunction

    // returns 1 when the payload list was the last one, i.e. the record is complete
    function automatic logic advance_list();
        if (cur_list >= LIST_PAYLOAD)
        begin
            restart_rule();
            return 1'b1;
        end
        cur_list  = cur_list + 3'd1;
        cur_phase = ST_COUNT;
        byte_cnt  = '0;
        shift_acc = '0;
        entry_idx = '0;
        return 1'b0;
    endfunction

    function automatic logic close_entry();
        entry_idx = entry_idx + 10'd1;
        if (entries_left != 0)
            entries_left = entries_left - 1'b1;
        if (entries_left == 0)
            return advance_list();
        open_entry();
        return 1'b0;
    endfunction

    function automatic rule_token_t make_token(input logic [3:0] kind, input logic [15:0] bidx,
                                               input logic [63:0] value, input logic done,
                                               input logic [1:0] err);
        rule_token_t t;
        t       = '0;
        t.kind  = kind;
        t.lsel  = (kind >= KIND_COUNT) ? cur_list : 3'd0;
        t.elem  = (kind >= KIND_MAC) ? entry_idx : 10'd0;
        t.bidx  = bidx;
        t.value = value;
        t.done  = done;
        t.err   = err;
        return t;
    endfunction

    function automatic logic parse_byte(input logic [7:0] b, output rule_token_t t);
        logic [15:0] half;
        t         = '0;
        shift_acc = {shift_acc[55:0], b};
        case (cur_phase)
            ST_ID:
            begin
                byte_cnt = byte_cnt + 16'd1;
                if (byte_cnt < 16'd4)
                    return 1'b0;
                t = make_token(KIND_ID, 16'd0, {32'd0, shift_acc[31:0]}, 1'b0, ERR_NONE);
                cur_phase = ST_NAME;
                byte_cnt  = '0;
                shift_acc = '0;
                return 1'b1;
            end
            ST_NAME:
            begin
                shift_acc = '0;
                // terminator is silent
                if (b == 8'd0)
                begin
                    cur_phase = ST_FLAGS;
                    byte_cnt  = '0;
                    return 1'b0;
                end
                if (byte_cnt >= 16'(MAX_NAME_LEN))
                begin
                    t = make_token(KIND_NAME, byte_cnt, {56'd0, b}, 1'b1, ERR_NAME_LONG);
                    restart_rule();
                    return 1'b1;
                end
                t = make_token(KIND_NAME, byte_cnt, {56'd0, b}, 1'b0, ERR_NONE);
                byte_cnt = byte_cnt + 16'd1;
                return 1'b1;
            end
            ST_FLAGS:
            begin
                t = make_token(KIND_FLAGS, 16'd0, {56'd0, b}, 1'b0, ERR_NONE);
                t.dir     = b[7:6];
                t.proto   = b[5:0];
                cur_list  = '0;
                cur_phase = ST_COUNT;
                byte_cnt  = '0;
                shift_acc = '0;
                entry_idx = '0;
                return 1'b1;
            end
            ST_COUNT:
            begin
                byte_cnt = byte_cnt + 16'd1;
                if (byte_cnt < 16'd8)
                    return 1'b0;
                if (shift_acc > 64'(MAX_ELEMENTS))
                begin
                    t = make_token(KIND_COUNT, 16'd0, shift_acc, 1'b1, ERR_COUNT);
                    restart_rule();
                    return 1'b1;
                end
                t = make_token(KIND_COUNT, 16'd0, shift_acc, 1'b0, ERR_NONE);
                entry_idx = '0;
                if (shift_acc == 64'd0)
                begin
                    t.done = advance_list();
                    return 1'b1;
                end
                entries_left = shift_acc[ELEM_W-1:0];
                open_entry();
                return 1'b1;
            end
            ST_MAC:
            begin
                shift_acc = '0;
                if (byte_cnt < 16'd6)
                    t = make_token(KIND_MAC, byte_cnt, {56'd0, b}, 1'b0, ERR_NONE);
                else
                    t = make_token(KIND_MAC_MASK, byte_cnt - 16'd6, {56'd0, b}, 1'b0, ERR_NONE);
                byte_cnt = byte_cnt + 16'd1;
                if (byte_cnt >= 16'd12)
                    t.done = close_entry();
                return 1'b1;
            end
            ST_IPVER:
            begin
                t = make_token(KIND_IP_VER, 16'd0, {56'd0, b}, 1'b0, ERR_NONE);
                addr_v4   = (b == 8'd4);
                cur_phase = ST_IP;
                byte_cnt  = '0;
                shift_acc = '0;
                return 1'b1;
            end
            ST_IP:
            begin
                shift_acc = '0;
                half = addr_v4 ? 16'd4 : 16'd16;
                if (byte_cnt < half)
                    t = make_token(KIND_IP, byte_cnt, {56'd0, b}, 1'b0, ERR_NONE);
                else
                    t = make_token(KIND_IP_MASK, byte_cnt - half, {56'd0, b}, 1'b0, ERR_NONE);
                byte_cnt = byte_cnt + 16'd1;
                if (byte_cnt >= {half[14:0], 1'b0})
                    t.done = close_entry();
                return 1'b1;
            end
            ST_PORT:
            begin
                byte_cnt = byte_cnt + 16'd1;
                if (byte_cnt == 16'd2)
                begin
                    t = make_token(KIND_PORT_LO, 16'd0, {48'd0, shift_acc[15:0]}, 1'b0, ERR_NONE);
                    shift_acc = '0;
                    return 1'b1;
                end
                if (byte_cnt < 16'd4)
                    return 1'b0;
                t = make_token(KIND_PORT_HI, 16'd0, {48'd0, shift_acc[15:0]}, 1'b0, ERR_NONE);
                t.done = close_entry();
                return 1'b1;
            end
            ST_PLEN:
            begin
                byte_cnt = byte_cnt + 16'd1;
                if (byte_cnt < 16'd2)
                    return 1'b0;
                pat_len = shift_acc[15:0];
                t = make_token(KIND_PLEN, 16'd0, {48'd0, pat_len}, 1'b0, ERR_NONE);
                byte_cnt  = '0;
                shift_acc = '0;
                if (pat_len == 16'd0)
                    t.done = close_entry();
                else
                    cur_phase = ST_PAT;
                return 1'b1;
            end
            ST_PAT:
            begin
                shift_acc = '0;
                t = make_token(KIND_PATTERN, byte_cnt, {56'd0, b}, 1'b0, ERR_NONE);
                byte_cnt = byte_cnt + 16'd1;
                if (byte_cnt >= pat_len)
                begin
                    cur_phase = ST_PMASK;
                    byte_cnt  = '0;
                end
                return 1'b1;
            end
            ST_PMASK:
            begin
                shift_acc = '0;
                t = make_token(KIND_PAT_MASK, byte_cnt, {56'd0, b}, 1'b0, ERR_NONE);
                byte_cnt = byte_cnt + 16'd1;
                if (byte_cnt >= pat_len)
                    t.done = close_entry();
                return 1'b1;
            end
            default:
            begin
                restart_rule();
                return 1'b0;
            end
        endcase
    endfunction

    function automatic void compare_field(input string fname, input logic [63:0] want,
                                          input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", fname, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        rule_token_t want;
        rule_token_t predicted;
        if (!rst_n)
        begin
            restart_rule();
            pending_tokens.delete();
        end
        else
        begin
            // compare before pushing: a byte's own token can never come out on the same edge
            if (token_valid && token_ready)
            begin
                if (pending_tokens.size() == 0)
                begin
                    $error("unexpected token transfer: kind %0d value 0x%0h",
                           field_kind, field_value);
                    fail_count++;
                end
                else
                begin
                    want = pending_tokens.pop_front();
                    compare_field("field_kind", 64'(want.kind), 64'(field_kind));
                    compare_field("list_select", 64'(want.lsel), 64'(list_select));
                    compare_field("element_index", 64'(want.elem), 64'(element_index));
                    compare_field("byte_index", 64'(want.bidx), 64'(byte_index));
                    compare_field("field_value", want.value, field_value);
                    compare_field("direction", 64'(want.dir), 64'(direction));
                    compare_field("protocol", 64'(want.proto), 64'(protocol));
                    compare_field("record_done", 64'(want.done), 64'(record_done));
                    compare_field("error_code", 64'(want.err), 64'(error_code));
                    tokens_checked++;
                    if (want.err != ERR_NONE)
                        error_tokens++;
                end
            end
            if (byte_valid && byte_ready)
            begin
                if (parse_byte(data_byte, predicted))
                    pending_tokens.push_back(predicted);
            end
        end
        outstanding  = pending_tokens.size();
        at_rec_start = (cur_phase == ST_ID) && (byte_cnt == 16'd0);
    end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb
    import frp_pkg::*;
();

    logic        clk;
    logic        rst_n;
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic        byte_ready;
    logic        token_valid;
    logic        token_ready;
    logic [3:0]  field_kind;
    logic [2:0]  list_select;
    logic [9:0]  element_index;
    logic [15:0] byte_index;
    logic [63:0] field_value;
    logic [1:0]  direction;
    logic [5:0]  protocol;
    logic        record_done;
    logic [1:0]  error_code;

    int          outstanding;
    bit          at_rec_start;
    int          fail_count;
    int          tokens_checked;
    int          error_tokens;

    bit          quiet;
    int          bytes_sent;
    int          n_rules;
    int          n_bursts;
    logic [7:0]  stream_q[$];
    logic [63:0] list_cnt[7];

    filter_rule_record_parser_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .data_byte     (data_byte),
        .byte_valid    (byte_valid),
        .byte_ready    (byte_ready),
        .token_valid   (token_valid),
        .token_ready   (token_ready),
        .field_kind    (field_kind),
        .list_select   (list_select),
        .element_index (element_index),
        .byte_index    (byte_index),
        .field_value   (field_value),
        .direction     (direction),
        .protocol      (protocol),
        .record_done   (record_done),
        .error_code    (error_code)
    );

    rule_token_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .data_byte      (data_byte),
        .byte_valid     (byte_valid),
        .byte_ready     (byte_ready),
        .token_valid    (token_valid),
        .token_ready    (token_ready),
        .field_kind     (field_kind),
        .list_select    (list_select),
        .element_index  (element_index),
        .byte_index     (byte_index),
        .field_value    (field_value),
        .direction      (direction),
        .protocol       (protocol),
        .record_done    (record_done),
        .error_code     (error_code),
        .outstanding    (outstanding),
        .at_rec_start   (at_rec_start),
        .fail_count     (fail_count),
        .tokens_checked (tokens_checked),
        .error_tokens   (error_tokens)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("FAIL filter_rule_record_parser_top");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // token side: runs of ready broken by random stalls
    initial
    begin
        int run;
        int gap;
        token_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            run = $urandom_range(1, 12);
            @(negedge clk) token_ready <= 1'b1;
            repeat (run - 1) @(negedge clk);
            gap = pick_gap();
            if (gap > 0)
            begin
                @(negedge clk) token_ready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    end

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_valid <= 1'b1;
        data_byte  <= b;
        @(posedge clk);
        while (!byte_ready)
            @(posedge clk);
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic send_stream();
        while (stream_q.size() > 0)
            send_byte(stream_q.pop_front());
    endtask

    task automatic drain_tokens(input int limit);
        int waited;
        waited = 0;
        byte_valid <= 1'b0;
        do
        begin
            @(negedge clk);
            waited++;
        end
        while (outstanding != 0 && waited < limit);
    endtask

    function automatic void push_be(input logic [63:0] v, input int n);
        for (int i = n - 1; i >= 0; i--)
            stream_q.push_back(v[8*i +: 8]);
    endfunction

    function automatic void push_rand(input int n);
        repeat (n) stream_q.push_back(8'($urandom));
    endfunction

    function automatic void fill_counts(input logic [63:0] v);
        foreach (list_cnt[k])
            list_cnt[k] = v;
    endfunction

    function automatic void roll_counts();
        int r;
        foreach (list_cnt[k])
        begin
            r = $urandom_range(0, 99);
            list_cnt[k] = (r < 40) ? 64'd0 : (r < 75) ? 64'd1 : (r < 93) ? 64'd2 : 64'd3;
        end
    endfunction

    // Serializes one rule record into stream_q using list_cnt. A negative flags or
    // pattern length means random. Stops right after the byte that triggers an error.
    function automatic void build_rule(input int name_len, input int flags, input int plen);
        int r;
        int len;
        int ver;
        push_be(64'($urandom), 4);
        if (name_len > MAX_NAME_LEN)
        begin
            repeat (MAX_NAME_LEN + 1) stream_q.push_back(8'($urandom_range(1, 255)));
            return;
        end
        repeat (name_len) stream_q.push_back(8'($urandom_range(1, 255)));
        stream_q.push_back(8'h00);
        push_be((flags < 0) ? 64'($urandom_range(0, 255)) : 64'(flags), 1);
        for (int k = 0; k < 7; k++)
        begin
            push_be(list_cnt[k], 8);
            if (list_cnt[k] > 64'(MAX_ELEMENTS))
                return;
            for (int e = 0; e < list_cnt[k]; e++)
            begin
                if (k <= LIST_DST_MAC)
                    push_rand(12);
                else if (k <= LIST_DST_IP)
                begin
                    r = $urandom_range(0, 99);
                    ver = (r < 45) ? 4 : (r < 80) ? 6 : $urandom_range(0, 255);
                    push_be(64'(ver), 1);
                    push_rand((ver == 4) ? 8 : 32);
                end
                else if (k <= LIST_DST_PORT)
                    push_rand(4);
                else
                begin
                    r = $urandom_range(0, 99);
                    if (plen >= 0)
                        len = plen;
                    else
                        len = (r < 15) ? 0 : (r < 95) ? $urandom_range(1, 5) : $urandom_range(6, 40);
                    push_be(64'(len), 2);
                    push_rand(2 * len);
                end
            end
        end
    endfunction

    // malformed input: raw bytes or a cut-off record, then zeros until the parser
    // is back at a record boundary
    task automatic send_burst();
        int cut;
        if ($urandom_range(0, 1) == 0)
            push_rand($urandom_range(1, 24));
        else
        begin
            roll_counts();
            build_rule($urandom_range(0, 6), -1, -1);
            cut = $urandom_range(1, stream_q.size() - 1);
            while (stream_q.size() > cut)
                void'(stream_q.pop_back());
        end
        send_stream();
        while (!at_rec_start)
            send_byte(8'h00);
        n_bursts++;
    endtask

    initial
    begin
        int r;
        int name_len;
        int rand_base;
        rst_n      = 1'b0;
        byte_valid = 1'b0;
        data_byte  = 8'h00;
        quiet      = 1'b0;
        bytes_sent = 0;
        n_rules    = 0;
        n_bursts   = 0;
        repeat (9) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;
        @(negedge clk);

        // shortest record: empty name, all lists empty
        fill_counts(64'd0);
        build_rule(0, 8'h00, -1);
        // longest legal name, all lists empty
        fill_counts(64'd0);
        build_rule(MAX_NAME_LEN, 8'hFF, -1);
        // count one above the limit on the first list
        fill_counts(64'd0);
        list_cnt[0] = 64'(MAX_ELEMENTS + 1);
        build_rule(2, -1, -1);
        // all-ones count on the last list
        fill_counts(64'd0);
        list_cnt[LIST_PAYLOAD] = '1;
        build_rule(1, -1, 3);
        // only the top count byte set
        fill_counts(64'd0);
        list_cnt[LIST_DST_IP] = 64'h0100_0000_0000_0000;
        build_rule(5, 8'h40, -1);
        // name one byte too long
        build_rule(MAX_NAME_LEN + 1, -1, -1);
        send_stream();
        n_rules += 6;
        drain_tokens(20000);

        // two entries per list, zero-length payloads, without idling
        quiet = 1'b1;
        fill_counts(64'd2);
        build_rule(3, 8'hA5, 0);
        send_stream();
        n_rules += 1;
        quiet = 1'b0;

        rand_base = bytes_sent;
        while (bytes_sent - rand_base < 400)
        begin
            quiet = ($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 99) < 10)
                send_burst();
            else
            begin
                roll_counts();
                r = $urandom_range(0, 99);
                if (r < 15)
                begin
                    case ($urandom_range(0, 2))
                        0: list_cnt[$urandom_range(0, 6)] = 64'(MAX_ELEMENTS + 1);
                        1: list_cnt[$urandom_range(0, 6)] = 64'(MAX_ELEMENTS + $urandom_range(2, 5000));
                        default: list_cnt[$urandom_range(0, 6)] = {$urandom, $urandom} | 64'h1_0000_0000;
                    endcase
                end
                r = $urandom_range(0, 99);
                name_len = (r < 3) ? MAX_NAME_LEN + 1 :
                           (r < 8) ? $urandom_range(13, MAX_NAME_LEN) : $urandom_range(0, 12);
                build_rule(name_len, -1, -1);
                send_stream();
                n_rules++;
            end
            if ($urandom_range(0, 19) == 0)
                drain_tokens(20000);
        end
        quiet = 1'b0;

        drain_tokens(20000);
        repeat (20) @(negedge clk);
        if (outstanding != 0)
            $error("%0d expected tokens never arrived", outstanding);

        $display("Covered %0d rule records and %0d malformed bursts in %0d bytes,", n_rules,
                 n_bursts, bytes_sent);
        $display("with longest and overlong names, oversized counts and a gapless run;");
        $display("%0d tokens checked, %0d error tokens", tokens_checked, error_tokens);
        if (fail_count == 0 && outstanding == 0)
            $display("PASS filter_rule_record_parser_top");
        else
            $display("FAIL filter_rule_record_parser_top");
        $finish;
    end

endmodule

### files.f
hw/rtl/frp_pkg.sv
hw/rtl/frp_front.sv
hw/rtl/frp_queue.sv
hw/rtl/frp_back.sv
hw/rtl/filter_rule_record_parser_top.sv
tb/rule_token_checker.sv
tb/tb.sv
